FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent assertions of the date converter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on clk that is switched off while arst_n is low.
`define DCC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Assertion on clk that is also checked while arst_n is low.
`define DCC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/dcc_pkg.sv
// ----------------------------------------------------------------------------
// dcc_pkg
// Types, constants and the month table of the day count to date converter.
// ----------------------------------------------------------------------------
package dcc_pkg;

	localparam int unsigned EPOCH_YEAR   = 1980;
	localparam int unsigned LEAP_DAYS    = 366;
	localparam int unsigned COMMON_DAYS  = 365;
	localparam int unsigned QUAD_DAYS    = LEAP_DAYS + 3 * COMMON_DAYS;
	localparam int unsigned MIN_PER_HOUR = 60;
	localparam int unsigned DAYS_PER_WK  = 7;

	// Reciprocals for the constant divisions; each estimate is at most one low.
	localparam int unsigned RECIP_QUAD_SHIFT = 20;
	localparam int unsigned RECIP_QUAD = (1 << RECIP_QUAD_SHIFT) / QUAD_DAYS;
	localparam int unsigned RECIP_WK_SHIFT = 18;
	localparam int unsigned RECIP_WK = (1 << RECIP_WK_SHIFT) / DAYS_PER_WK;
	localparam int unsigned RECIP_HOUR_SHIFT = 16;
	localparam int unsigned RECIP_HOUR = (1 << RECIP_HOUR_SHIFT) / MIN_PER_HOUR;

	typedef struct packed {
		logic [14:0] days_since_epoch;
		logic [10:0] minutes_of_day;
	} day_in_t;

	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day_of_month;
		logic [2:0]  weekday;
		logic [5:0]  hour;
		logic [5:0]  minute;
	} date_out_t;

	// After the division stages: four-year cycle index and the day inside it.
	typedef struct packed {
		logic [4:0]  quad;
		logic [10:0] quad_rem;
		logic [2:0]  weekday;
		logic [5:0]  hour;
		logic [5:0]  minute;
	} dcc_div_t;

	// After the year stage: year, zero-based day of year and leap flag.
	typedef struct packed {
		logic [11:0] year;
		logic [8:0]  doy;
		logic        leap;
		logic [2:0]  weekday;
		logic [5:0]  hour;
		logic [5:0]  minute;
	} dcc_ydate_t;

	// Zero-based day of year on which month m (zero-based) begins.
	function automatic logic [8:0] month_start(input logic leap, input logic [3:0] m);
		logic [8:0] base;
		case (m)
			4'd0:    base = 9'd0;
			4'd1:    base = 9'd31;
			4'd2:    base = 9'd59;
			4'd3:    base = 9'd90;
			4'd4:    base = 9'd120;
			4'd5:    base = 9'd151;
			4'd6:    base = 9'd181;
			4'd7:    base = 9'd212;
			4'd8:    base = 9'd243;
			4'd9:    base = 9'd273;
			4'd10:   base = 9'd304;
			4'd11:   base = 9'd334;
			default: base = 9'd0;
		endcase
		return (leap && (m >= 4'd2)) ? base + 9'd1 : base;
	endfunction

endpackage

FILE: design/dcc_divide.sv
// ----------------------------------------------------------------------------
// dcc_divide
// Two stages: reciprocal estimates, then remainder and one-step correction.
// ----------------------------------------------------------------------------
module dcc_divide import dcc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     up_valid,
	output logic     up_stall,
	input  day_in_t  up_data,
	output logic     dn_valid,
	input  logic     dn_stall,
	output dcc_div_t dn_data
);

	logic        valid_s1, valid_s2;
	logic        en_s1, en_s2;
	logic [14:0] days_s1;
	logic [4:0]  q4_s1;
	logic [15:0] d1_s1;
	logic [12:0] q7_s1;
	logic [10:0] mins_s1;
	logic [5:0]  qh_s1;
	dcc_div_t    div_s2;

	logic [24:0] prod4;
	logic [31:0] prod7;
	logic [21:0] prodh;
	logic [15:0] d1;
	logic [15:0] r4_raw;
	logic [15:0] r7_raw;
	logic [11:0] rh_raw;
	dcc_div_t    div_c;

	assign en_s2    = !valid_s2 || !dn_stall;
	assign en_s1    = !valid_s1 || en_s2;
	assign up_stall = !en_s1;
	assign dn_valid = valid_s2;
	assign dn_data  = div_s2;

	assign d1    = 16'(up_data.days_since_epoch) + 16'd1;
	assign prod4 = 25'(up_data.days_since_epoch) * 25'(RECIP_QUAD);
	assign prod7 = 32'(d1) * 32'(RECIP_WK);
	assign prodh = 22'(up_data.minutes_of_day) * 22'(RECIP_HOUR);

	// The estimates may fall one short; the remainders then reach one divisor
	// too many and are pulled back below.
	assign r4_raw = 16'(days_s1) - 16'(16'(q4_s1) * 16'(QUAD_DAYS));
	assign r7_raw = d1_s1 - 16'(16'(q7_s1) * 16'(DAYS_PER_WK));
	assign rh_raw = 12'(mins_s1) - 12'(12'(qh_s1) * 12'(MIN_PER_HOUR));

	always_comb begin
		if (r4_raw >= 16'(QUAD_DAYS)) begin
			div_c.quad     = q4_s1 + 5'd1;
			div_c.quad_rem = 11'(r4_raw - 16'(QUAD_DAYS));
		end else begin
			div_c.quad     = q4_s1;
			div_c.quad_rem = 11'(r4_raw);
		end
		if (r7_raw >= 16'(DAYS_PER_WK)) begin
			div_c.weekday = 3'(r7_raw - 16'(DAYS_PER_WK)) + 3'd1;
		end else begin
			div_c.weekday = 3'(r7_raw) + 3'd1;
		end
		if (rh_raw >= 12'(MIN_PER_HOUR)) begin
			div_c.hour   = qh_s1 + 6'd1;
			div_c.minute = 6'(rh_raw - 12'(MIN_PER_HOUR));
		end else begin
			div_c.hour   = qh_s1;
			div_c.minute = 6'(rh_raw);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= up_valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && up_valid) begin
			days_s1 <= up_data.days_since_epoch;
			q4_s1   <= prod4[RECIP_QUAD_SHIFT +: 5];
			d1_s1   <= d1;
			q7_s1   <= prod7[RECIP_WK_SHIFT +: 13];
			mins_s1 <= up_data.minutes_of_day;
			qh_s1   <= prodh[RECIP_HOUR_SHIFT +: 6];
		end
		if (en_s2 && valid_s1) begin
			div_s2 <= div_c;
		end
	end

endmodule

FILE: design/dcc_year.sv
// ----------------------------------------------------------------------------
// dcc_year
// Splits the day within a four-year cycle into year and day of year.
// ----------------------------------------------------------------------------
module dcc_year import dcc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       up_valid,
	output logic       up_stall,
	input  dcc_div_t   up_data,
	output logic       dn_valid,
	input  logic       dn_stall,
	output dcc_ydate_t dn_data
);

	localparam int unsigned Y1_START = LEAP_DAYS;
	localparam int unsigned Y2_START = Y1_START + COMMON_DAYS;
	localparam int unsigned Y3_START = Y2_START + COMMON_DAYS;

	logic       valid_s3;
	logic       en_s3;
	dcc_ydate_t yd_s3;
	dcc_ydate_t yd_c;
	logic [1:0] yoff;

	assign en_s3    = !valid_s3 || !dn_stall;
	assign up_stall = !en_s3;
	assign dn_valid = valid_s3;
	assign dn_data  = yd_s3;

	// Every cycle starts with a leap year: all years from 1980 to 2069 that
	// are multiples of four are leap years, 2000 included.
	always_comb begin
		if (up_data.quad_rem < 11'(Y1_START)) begin
			yoff       = 2'd0;
			yd_c.doy   = 9'(up_data.quad_rem);
		end else if (up_data.quad_rem < 11'(Y2_START)) begin
			yoff       = 2'd1;
			yd_c.doy   = 9'(up_data.quad_rem - 11'(Y1_START));
		end else if (up_data.quad_rem < 11'(Y3_START)) begin
			yoff       = 2'd2;
			yd_c.doy   = 9'(up_data.quad_rem - 11'(Y2_START));
		end else begin
			yoff       = 2'd3;
			yd_c.doy   = 9'(up_data.quad_rem - 11'(Y3_START));
		end
		yd_c.leap    = (yoff == 2'd0);
		yd_c.year    = 12'(EPOCH_YEAR) + 12'({up_data.quad, 2'b00}) + 12'(yoff);
		yd_c.weekday = up_data.weekday;
		yd_c.hour    = up_data.hour;
		yd_c.minute  = up_data.minute;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en_s3) begin
			valid_s3 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && up_valid) begin
			yd_s3 <= yd_c;
		end
	end

endmodule

FILE: design/dcc_month.sv
// ----------------------------------------------------------------------------
// dcc_month
// Finds month and day of month from the day of year; holds the result.
// ----------------------------------------------------------------------------
module dcc_month import dcc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       up_valid,
	output logic       up_stall,
	input  dcc_ydate_t up_data,
	output logic       dn_valid,
	input  logic       dn_stall,
	output date_out_t  dn_data
);

	logic       valid_s4;
	logic       en_s4;
	date_out_t  date_s4;
	date_out_t  date_c;
	logic [3:0] mon_idx;
	logic [8:0] day_idx;

	assign en_s4    = !valid_s4 || !dn_stall;
	assign up_stall = !en_s4;
	assign dn_valid = valid_s4;
	assign dn_data  = date_s4;

	// Eleven independent compares against the month starts; the last hit wins.
	always_comb begin
		mon_idx = 4'd0;
		for (int m = 1; m < 12; m++) begin
			if (up_data.doy >= month_start(up_data.leap, 4'(m))) begin
				mon_idx = 4'(m);
			end
		end
	end

	assign day_idx = up_data.doy - month_start(up_data.leap, mon_idx);

	always_comb begin
		date_c.year         = up_data.year;
		date_c.month        = mon_idx + 4'd1;
		date_c.day_of_month = 5'(day_idx) + 5'd1;
		date_c.weekday      = up_data.weekday;
		date_c.hour         = up_data.hour;
		date_c.minute       = up_data.minute;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en_s4) begin
			valid_s4 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4 && up_valid) begin
			date_s4 <= date_c;
		end
	end

endmodule

FILE: design/day_count_to_calendar_date.sv
// ----------------------------------------------------------------------------
// day_count_to_calendar_date
// Converts days since 1980-01-01 and minutes since midnight into a date.
// ----------------------------------------------------------------------------
//  Channel   Handshake            Payload     Role
//  day       day_valid/day_stall  day_data    day count and minute count in
//  date      date_valid/date_stall date_data  year, month, day, weekday, time out
//
//  Each transaction passes through four register stages: the reciprocal
//  multipliers, the remainder correction, the year split and the month
//  compare. A new transaction may enter every cycle while day_stall is low.
//  Reset clears only the valid bits of the four stages.
//  A stall on the date side holds the full stages and travels back to
//  day_stall only when every stage ahead holds a transaction.
// ----------------------------------------------------------------------------
module day_count_to_calendar_date import dcc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      day_valid,
	output logic      day_stall,
	input  day_in_t   day_data,
	output logic      date_valid,
	input  logic      date_stall,
	output date_out_t date_data
);

	// Links between the pipeline sections, each a valid/stall pair with its
	// payload, the same handshake as on the outside ports.
	logic       div_valid;
	logic       div_stall;
	dcc_div_t   div_data;
	logic       yd_valid;
	logic       yd_stall;
	dcc_ydate_t yd_data;

	// Stages one and two: the day count is divided by the length of a
	// four-year cycle, the day count plus one by seven for the weekday (day
	// zero is a Tuesday), and the minute count by sixty. The hour is not
	// wrapped at 24, so minute counts past one day give hours up to 34.
	dcc_divide u_divide (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (day_valid),
		.up_stall (day_stall),
		.up_data  (day_data),
		.dn_valid (div_valid),
		.dn_stall (div_stall),
		.dn_data  (div_data)
	);

	// Stage three: the day within the cycle picks one of the four years.
	dcc_year u_year (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (div_valid),
		.up_stall (div_stall),
		.up_data  (div_data),
		.dn_valid (yd_valid),
		.dn_stall (yd_stall),
		.dn_data  (yd_data)
	);

	// Stage four: month and day of month from the day of year; this stage
	// is also the output register of the date channel.
	dcc_month u_month (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (yd_valid),
		.up_stall (yd_stall),
		.up_data  (yd_data),
		.dn_valid (date_valid),
		.dn_stall (date_stall),
		.dn_data  (date_data)
	);

endmodule

FILE: design/dcc_checker.sv
// ----------------------------------------------------------------------------
// dcc_checker
// Port-level checks of the date converter, attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dcc_checker import dcc_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      day_valid,
	input logic      day_stall,
	input logic      date_valid,
	input logic      date_stall,
	input date_out_t date_data
);

	logic date_hold;
	logic day_hold;
	logic fields_ok;

	assign date_hold = date_valid && date_stall;
	assign day_hold  = day_valid && day_stall;
	assign fields_ok = (date_data.month >= 4'd1) && (date_data.month <= 4'd12) &&
		(date_data.day_of_month >= 5'd1) && (date_data.weekday >= 3'd1) &&
		(date_data.minute <= 6'd59);

	`DCC_ASSERT(a_hold_stalled, date_hold |=> date_valid && $stable(date_data), "stalled date moved")
	`DCC_ASSERT(a_fields_in_range, date_valid |-> fields_ok, "date field out of range")
	`DCC_ASSERT(a_stall_only_when_full, day_hold |-> date_hold, "day stalled with date side free")
	`DCC_ASSERT_ALWAYS(a_reset_empty, !arst_n |-> !date_valid, "date shown during reset")

endmodule

bind day_count_to_calendar_date dcc_checker u_dcc_checker (.*);
